@@ hw/rtl/rde_pkg.sv @@
package rde_pkg;

   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned MAP_DEPTH   = 256;
   localparam int unsigned MAX_DIGITS  = 32;
   localparam int unsigned DIGIT_IDX_W = 5;
   localparam int unsigned DIGIT_CNT_W = 6;
   localparam int unsigned DIV_BITS    = 8;
   localparam int unsigned DIV_CYCLES  = VALUE_W / DIV_BITS;
   localparam int unsigned DIV_STEP_W  = 2;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_CONVERT = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_SIGN,
      BK_READ,
      BK_SEND
   } back_state_type;

endpackage

@@ hw/rtl/rde_if.sv @@
interface rde_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [7:0]         symbol;
   logic signed [31:0] value;

   modport source (output valid, output opcode, output symbol, output value, input ready);
   modport sink   (input valid, input opcode, input symbol, input value, output ready);
endinterface

interface rde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

@@ hw/rtl/radix_digit_emitter.sv @@
// Clear and append items wait while a conversion is queued or running.
// Convert: the 8-bit-per-cycle divider produces the digits, then each character is a table
// read followed by an output load, which waits for the output register to be free.
// Up to two convert items queue behind the one being worked; one output register decouples rsp.
// Synchronous active-high reset empties the alphabet and the queue; no clearing pass.
module radix_digit_emitter #(
   parameter int unsigned MAX_SYMBOLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   rde_req_if.sink     req_chan,
   rde_rsp_if.source   rsp_chan
);

   localparam int unsigned LEN_W = $clog2(MAX_SYMBOLS + 1);
   localparam int unsigned IDX_W = $clog2(MAX_SYMBOLS);
   localparam int unsigned JOB_W = 1 + rde_pkg::VALUE_W + LEN_W;

   logic                       back_busy;
   logic                       q_full;
   logic                       q_valid;
   logic                       q_push;
   logic                       q_pop;
   logic [JOB_W-1:0]           q_push_data;
   logic [JOB_W-1:0]           q_pop_data;
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_addr;
   logic [rde_pkg::CHAR_W-1:0] mem_data;

   rde_front #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .back_busy (back_busy),
      .q_full    (q_full),
      .q_empty   (!q_valid),
      .q_push    (q_push),
      .q_data    (q_push_data),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_data  (mem_data)
   );

   rde_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_pop_data)
   );

   rde_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_pop_data),
      .q_pop    (q_pop),
      .mem_we   (mem_we),
      .mem_addr (mem_addr),
      .mem_data (mem_data),
      .busy     (back_busy),
      .rsp_chan (rsp_chan)
   );

   // table must not change under a running conversion
   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (!back_busy && !q_valid))
      else $error("symbol table written during conversion");

   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job queue overflow");

   // digits come from a valid alphabet, so a minus is never final and no byte is zero
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.character == rde_pkg::CHAR_MINUS)) |-> !rsp_chan.last)
      else $error("minus sign marked last");

   a_no_nul_char: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.character != rde_pkg::CHAR_NUL))
      else $error("zero byte emitted");

endmodule

@@ hw/rtl/rde_front.sv @@
module rde_front #(
   parameter int unsigned MAX_SYMBOLS = 64,
   localparam int unsigned LEN_W = $clog2(MAX_SYMBOLS + 1),
   localparam int unsigned IDX_W = $clog2(MAX_SYMBOLS),
   localparam int unsigned JOB_W = 1 + rde_pkg::VALUE_W + LEN_W
) (
   input  logic                          clock,
   input  logic                          reset,
   rde_req_if.sink                       req_chan,
   input  logic                          back_busy,
   input  logic                          q_full,
   input  logic                          q_empty,
   output logic                          q_push,
   output logic [JOB_W-1:0]              q_data,
   output logic                          mem_we,
   output logic [IDX_W-1:0]              mem_addr,
   output logic [rde_pkg::CHAR_W-1:0]    mem_data
);

   logic [LEN_W-1:0]              len_ff, len_in;
   logic                          bad_ff, bad_in;
   logic [rde_pkg::MAP_DEPTH-1:0] seen_ff, seen_in;

   rde_pkg::op_type               op;
   logic                          ready;
   logic                          accept;
   logic                          forbidden;
   logic [rde_pkg::VALUE_W-1:0]   raw;
   logic [rde_pkg::VALUE_W-1:0]   mag;

   assign op  = rde_pkg::op_type'(req_chan.opcode);
   assign raw = req_chan.value;
   assign mag = raw[rde_pkg::VALUE_W-1] ? (~raw + 32'd1) : raw;

   // alphabet edits wait until no conversion is queued or in progress
   always_comb begin
      unique case (op)
         rde_pkg::OP_CONVERT: ready = !q_full;
         rde_pkg::OP_CLEAR,
         rde_pkg::OP_APPEND:  ready = !back_busy && q_empty;
         default:             ready = 1'b1;
      endcase
   end

   assign req_chan.ready = ready;
   assign accept         = req_chan.valid && ready;

   assign forbidden = (req_chan.symbol == rde_pkg::CHAR_NUL) ||
                      (req_chan.symbol == rde_pkg::CHAR_PLUS) ||
                      (req_chan.symbol == rde_pkg::CHAR_MINUS);

   assign q_data   = {raw[rde_pkg::VALUE_W-1], mag, len_ff};
   assign mem_addr = len_ff[IDX_W-1:0];
   assign mem_data = req_chan.symbol;

   always_comb begin
      len_in  = len_ff;
      bad_in  = bad_ff;
      seen_in = seen_ff;
      mem_we  = 1'b0;
      q_push  = 1'b0;
      if (accept) begin
         unique case (op)
            rde_pkg::OP_CLEAR: begin
               seen_in = '0;
               len_in  = '0;
               bad_in  = 1'b0;
            end
            rde_pkg::OP_APPEND: begin
               if (forbidden || seen_ff[req_chan.symbol]) begin
                  bad_in = 1'b1;
               end
               seen_in[req_chan.symbol] = 1'b1;
               if (len_ff == LEN_W'(MAX_SYMBOLS)) begin
                  bad_in = 1'b1;
               end else begin
                  mem_we = 1'b1;
                  len_in = LEN_W'(len_ff + 1'b1);
               end
            end
            rde_pkg::OP_CONVERT: begin
               // invalid alphabet or fewer than two symbols: item dropped, nothing emitted
               q_push = !bad_ff && (len_ff >= LEN_W'(2));
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         bad_ff  <= 1'b0;
         seen_ff <= '0;
      end else begin
         len_ff  <= len_in;
         bad_ff  <= bad_in;
         seen_ff <= seen_in;
      end
   end

endmodule

@@ hw/rtl/rde_queue.sv @@
module rde_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] ent_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/rde_back.sv @@
module rde_back #(
   parameter int unsigned MAX_SYMBOLS = 64,
   localparam int unsigned LEN_W = $clog2(MAX_SYMBOLS + 1),
   localparam int unsigned IDX_W = $clog2(MAX_SYMBOLS),
   localparam int unsigned JOB_W = 1 + rde_pkg::VALUE_W + LEN_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  logic [JOB_W-1:0]              q_data,
   output logic                          q_pop,
   input  logic                          mem_we,
   input  logic [IDX_W-1:0]              mem_addr,
   input  logic [rde_pkg::CHAR_W-1:0]    mem_data,
   output logic                          busy,
   rde_rsp_if.source                     rsp_chan
);

   localparam int unsigned T_W = IDX_W + 1;
   localparam int unsigned VW  = rde_pkg::VALUE_W;
   localparam int unsigned CW  = rde_pkg::CHAR_W;
   localparam int unsigned DBW = rde_pkg::DIV_BITS;
   localparam int unsigned SW  = rde_pkg::DIV_STEP_W;
   localparam int unsigned NW  = rde_pkg::DIGIT_CNT_W;
   localparam int unsigned NIW = rde_pkg::DIGIT_IDX_W;

   rde_pkg::back_state_type state_ff, state_in;

   logic [VW-1:0]    mag_ff, mag_in;
   logic [LEN_W-1:0] base_ff, base_in;
   logic             neg_ff, neg_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [NW-1:0]    ndig_ff, ndig_in;
   logic [IDX_W-1:0] stack_ff [rde_pkg::MAX_DIGITS];
   logic [CW-1:0]    rd_data_ff;
   logic [CW-1:0]    char_ff, char_in;
   logic             last_ff, last_in;
   logic             out_valid_ff, out_valid_in;

   logic [CW-1:0]    symbol_mem [MAX_SYMBOLS];

   logic [IDX_W-1:0] div_rem;
   logic [DBW-1:0]   div_q;
   logic [VW-1:0]    mag_shift;
   logic [NW-1:0]    ndig_dec;
   logic [IDX_W-1:0] rd_addr;

   logic out_free;
   logic div_last;
   logic div_done;
   logic load_sign;
   logic load_digit;
   logic mem_rd;

   // restoring division of the magnitude by the base, DIV_BITS quotient bits a cycle;
   // the quotient shifts in at the bottom so mag_ff holds it once the last step of a pass is done
   always_comb begin : div_slice
      logic [T_W-1:0]   part;
      logic [IDX_W-1:0] r;
      r     = rem_ff;
      div_q = '0;
      for (int i = 0; i < DBW; i++) begin
         part = {r, mag_ff[VW-1-i]};
         if (part >= T_W'(base_ff)) begin
            r                = IDX_W'(part - T_W'(base_ff));
            div_q[DBW-1-i]   = 1'b1;
         end else begin
            r = part[IDX_W-1:0];
         end
      end
      div_rem = r;
   end

   assign mag_shift = {mag_ff[VW-DBW-1:0], div_q};
   assign ndig_dec  = NW'(ndig_ff - 1'b1);
   assign rd_addr   = stack_ff[ndig_dec[NIW-1:0]];
   assign out_free  = !out_valid_ff || rsp_chan.ready;

   // control outputs
   always_comb begin
      q_pop      = (state_ff == rde_pkg::BK_IDLE) && q_valid;
      div_last   = (state_ff == rde_pkg::BK_DIV) &&
                   (step_ff == SW'(rde_pkg::DIV_CYCLES - 1));
      div_done   = div_last && ((mag_shift == '0) ||
                   (ndig_ff == NW'(rde_pkg::MAX_DIGITS - 1)));
      load_sign  = (state_ff == rde_pkg::BK_SIGN) && out_free;
      load_digit = (state_ff == rde_pkg::BK_SEND) && out_free;
      mem_rd     = (state_ff == rde_pkg::BK_READ);
      busy       = (state_ff != rde_pkg::BK_IDLE);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rde_pkg::BK_IDLE: begin
            if (q_valid) begin
               state_in = rde_pkg::BK_DIV;
            end
         end
         rde_pkg::BK_DIV: begin
            if (div_done) begin
               state_in = neg_ff ? rde_pkg::BK_SIGN : rde_pkg::BK_READ;
            end
         end
         rde_pkg::BK_SIGN: begin
            if (out_free) begin
               state_in = rde_pkg::BK_READ;
            end
         end
         rde_pkg::BK_READ: begin
            state_in = rde_pkg::BK_SEND;
         end
         rde_pkg::BK_SEND: begin
            if (out_free) begin
               state_in = (ndig_ff == NW'(1)) ? rde_pkg::BK_IDLE : rde_pkg::BK_READ;
            end
         end
         default: begin
            state_in = rde_pkg::BK_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      mag_in  = mag_ff;
      base_in = base_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      ndig_in = ndig_ff;
      if (q_pop) begin
         neg_in  = q_data[JOB_W-1];
         mag_in  = q_data[LEN_W +: VW];
         base_in = q_data[LEN_W-1:0];
         rem_in  = '0;
         step_in = '0;
         ndig_in = '0;
      end else if (state_ff == rde_pkg::BK_DIV) begin
         mag_in  = mag_shift;
         rem_in  = div_rem;
         step_in = SW'(step_ff + 1'b1);
         if (div_last) begin
            rem_in  = '0;
            step_in = '0;
            ndig_in = NW'(ndig_ff + 1'b1);
         end
      end else if (load_digit) begin
         ndig_in = ndig_dec;
      end

      char_in = char_ff;
      last_in = last_ff;
      if (load_sign) begin
         char_in = rde_pkg::CHAR_MINUS;
         last_in = 1'b0;
      end else if (load_digit) begin
         char_in = rd_data_ff;
         last_in = (ndig_ff == NW'(1));
      end

      if (load_sign || load_digit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rde_pkg::BK_IDLE;
         step_ff      <= '0;
         ndig_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ndig_ff      <= ndig_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      base_ff <= base_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (div_last) begin
         stack_ff[ndig_ff[NIW-1:0]] <= div_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         symbol_mem[mem_addr] <= mem_data;
      end
      if (mem_rd) begin
         rd_data_ff <= symbol_mem[rd_addr];
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.character = char_ff;
   assign rsp_chan.last      = last_ff;

endmodule

@@ tb/sv/rde_checker.sv @@
`timescale 1ns / 100ps
module rde_checker #(
   parameter int unsigned MAX_SYMBOLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   rde_req_if          req_mon,
   rde_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending_count
);

   typedef struct packed {
      logic [rde_pkg::CHAR_W-1:0] character;
      logic                       last;
   } char_beat_type;

   char_beat_type              expected_chars[$];
   logic [rde_pkg::CHAR_W-1:0] symbol_table [MAX_SYMBOLS];
   int unsigned                alpha_len;
   bit                         seen_map [rde_pkg::MAP_DEPTH];
   bit                         alpha_bad;

   function automatic void push_char(logic [rde_pkg::CHAR_W-1:0] ch, logic lst);
      char_beat_type beat;
      beat.character = ch;
      beat.last      = lst;
      expected_chars.push_back(beat);
   endfunction

   function automatic void clear_alphabet();
      foreach (seen_map[i]) seen_map[i] = 1'b0;
      alpha_len = 0;
      alpha_bad = 1'b0;
   endfunction

   function automatic void predict_chars(logic [1:0] op, logic [rde_pkg::CHAR_W-1:0] sym,
                                         logic [rde_pkg::VALUE_W-1:0] raw);
      logic [rde_pkg::VALUE_W-1:0] mag;
      logic [rde_pkg::VALUE_W-1:0] base;
      logic [rde_pkg::CHAR_W-1:0]  digits [rde_pkg::MAX_DIGITS];
      int                          ndig;
      case (op)
         rde_pkg::OP_CLEAR: begin
            clear_alphabet();
         end
         rde_pkg::OP_APPEND: begin
            if (sym == rde_pkg::CHAR_NUL || sym == rde_pkg::CHAR_PLUS ||
                sym == rde_pkg::CHAR_MINUS)
               alpha_bad = 1'b1;
            if (seen_map[sym])
               alpha_bad = 1'b1;
            seen_map[sym] = 1'b1;
            // a full table keeps its length and just poisons the alphabet
            if (alpha_len >= MAX_SYMBOLS) begin
               alpha_bad = 1'b1;
            end else begin
               symbol_table[alpha_len] = sym;
               alpha_len++;
            end
         end
         rde_pkg::OP_CONVERT: begin
            base = alpha_len;
            if (!alpha_bad && base >= 2 && base <= MAX_SYMBOLS) begin
               if (raw[rde_pkg::VALUE_W-1]) begin
                  mag = ~raw + 1'b1;
                  push_char(rde_pkg::CHAR_MINUS, 1'b0);
               end else begin
                  mag = raw;
               end
               ndig = 0;
               do begin
                  digits[ndig] = symbol_table[mag % base];
                  ndig++;
                  mag = mag / base;
               end while (mag != 0 && ndig < rde_pkg::MAX_DIGITS);
               for (int k = ndig - 1; k >= 0; k--)
                  push_char(digits[k], k == 0);
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      char_beat_type want;
      if (reset) begin
         expected_chars.delete();
         clear_alphabet();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_chars.size() == 0) begin
               fail_count++;
               $error("unexpected character transfer: character %h, last %b",
                      rsp_mon.character, rsp_mon.last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_mon.character !== want.character) begin
                  fail_count++;
                  $error("character: expected %h, actual %h", want.character,
                         rsp_mon.character);
               end
               if (rsp_mon.last !== want.last) begin
                  fail_count++;
                  $error("last: expected %b, actual %b", want.last, rsp_mon.last);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_chars(req_mon.opcode, req_mon.symbol, req_mon.value);
      end
      pending_count = expected_chars.size();
   end

endmodule

@@ tb/sv/tb_radix_digit_emitter.sv @@
`timescale 1ns / 100ps
module tb_radix_digit_emitter;

   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam int unsigned MAX_SYMBOLS    = 64;
   localparam int unsigned RANDOM_ITEMS   = 250;
   localparam int unsigned QUIET_ITEMS    = 40;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES   = 400;

   logic                       clock;
   logic                       reset;
   bit                         quiet;
   int unsigned                items_sent;
   int unsigned                idle_cycles;
   int unsigned                fail_count;
   int unsigned                pending_count;
   bit                         sym_used [rde_pkg::MAP_DEPTH];
   logic [rde_pkg::CHAR_W-1:0] alphabet_q[$];

   rde_req_if req_bus ();
   rde_rsp_if rsp_bus ();

   radix_digit_emitter #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   rde_checker #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // called at a falling edge, returns at a falling edge after the transfer
   task automatic send_item(input logic [1:0] op, input logic [rde_pkg::CHAR_W-1:0] sym,
                            input logic [rde_pkg::VALUE_W-1:0] val);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.symbol <= sym;
      req_bus.value  <= val;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      if (op != OP_UNUSED)
         items_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   function automatic logic [rde_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(0, 5))
         1: return $urandom_range(0, 100);
         2: return -$urandom_range(1, 100);
         3: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h7FFF_FFFF;
               default: return 32'h8000_0000;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [rde_pkg::CHAR_W-1:0] fresh_symbol();
      logic [rde_pkg::CHAR_W-1:0] s;
      do s = 8'($urandom_range(1, 255));
      while (sym_used[s] || s == rde_pkg::CHAR_PLUS || s == rde_pkg::CHAR_MINUS);
      sym_used[s] = 1'b1;
      return s;
   endfunction

   task automatic send_convert(input logic [rde_pkg::VALUE_W-1:0] val);
      send_item(rde_pkg::OP_CONVERT, 8'($urandom_range(0, 255)), val);
   endtask

   task automatic send_append(input logic [rde_pkg::CHAR_W-1:0] sym);
      send_item(rde_pkg::OP_APPEND, sym, $urandom);
   endtask

   // clear, then n distinct legal symbols; past MAX_SYMBOLS this overflows
   task automatic build_alphabet(input int n);
      logic [rde_pkg::CHAR_W-1:0] s;
      send_item(rde_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), $urandom);
      foreach (sym_used[i]) sym_used[i] = 1'b0;
      alphabet_q.delete();
      repeat (n) begin
         s = fresh_symbol();
         alphabet_q.push_back(s);
         send_append(s);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      int pick;
      int n;
      req_bus.valid  = 1'b0;
      req_bus.opcode = rde_pkg::OP_CLEAR;
      req_bus.symbol = '0;
      req_bus.value  = '0;
      reset          = 1'b1;
      quiet          = 1'b0;
      items_sent     = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty alphabet, then a single symbol: both too short
      send_convert(32'd0);
      send_append("0");
      send_convert(32'd5);
      send_append("1");
      send_convert(32'd0);
      send_convert(32'hFFFF_FFFF);
      send_convert(32'h7FFF_FFFF);
      send_convert(32'h8000_0000);
      // unused opcode must leave the alphabet alone
      send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
      send_convert(32'd2);
      send_append(rde_pkg::CHAR_PLUS);
      send_convert(32'd7);
      send_item(rde_pkg::OP_CLEAR, 8'hFF, 32'hFFFF_FFFF);
      send_append("a");
      send_append(8'hFF);
      send_append("a");
      send_convert(32'd9);
      send_item(rde_pkg::OP_CLEAR, 8'h00, 32'h0);
      send_append(rde_pkg::CHAR_NUL);
      send_append("b");
      send_convert(32'd3);
      send_item(rde_pkg::OP_CLEAR, 8'h55, 32'h5555_5555);
      send_append(rde_pkg::CHAR_MINUS);
      send_append(8'h80);
      send_convert(32'd1);
      wait_drained();

      // widest alphabet, then one append past the end
      build_alphabet(MAX_SYMBOLS);
      send_convert(32'h8000_0000);
      send_convert(random_value());
      send_append(fresh_symbol());
      send_convert(random_value());

      while (items_sent < RANDOM_ITEMS) begin
         quiet = (items_sent + QUIET_ITEMS >= RANDOM_ITEMS);
         pick  = $urandom_range(0, 19);
         if (pick < 13) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, MAX_SYMBOLS)
                                            : $urandom_range(2, 16);
            build_alphabet(n);
            repeat ($urandom_range(1, 4)) send_convert(random_value());
         end else if (pick < 16) begin
            case ($urandom_range(0, 3))
               0: begin
                  build_alphabet($urandom_range(1, 8));
                  case ($urandom_range(0, 2))
                     0: send_append(rde_pkg::CHAR_NUL);
                     1: send_append(rde_pkg::CHAR_PLUS);
                     default: send_append(rde_pkg::CHAR_MINUS);
                  endcase
               end
               1: begin
                  build_alphabet($urandom_range(1, 8));
                  send_append(alphabet_q[$urandom_range(0, alphabet_q.size() - 1)]);
               end
               2: build_alphabet($urandom_range(MAX_SYMBOLS + 1, MAX_SYMBOLS + 3));
               default: build_alphabet($urandom_range(0, 1));
            endcase
            repeat ($urandom_range(1, 2)) send_convert(random_value());
         end else if (pick < 19) begin
            repeat ($urandom_range(1, 6))
               send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         random_value());
         end else begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/rde_pkg.sv
hw/rtl/rde_if.sv
hw/rtl/rde_front.sv
hw/rtl/rde_queue.sv
hw/rtl/rde_back.sv
hw/rtl/radix_digit_emitter.sv
tb/sv/rde_checker.sv
tb/sv/tb_radix_digit_emitter.sv
